[rtl/tan_pkg.sv]
// Shared types and constants of the table-based Gaussian noise adder.
package tan_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_RADIUS = 2'd0,
    CMD_LOAD_COSINE = 2'd1,
    CMD_SAMPLE      = 2'd2
  } cmd_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_NOISE_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LCG_SEED     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMPLEX_MODE = 2'd2;

  localparam int CMD_W        = 2;
  localparam int SCALE_W      = 16;
  localparam int TABLE_WORD_W = 16;
  localparam int LCG_W        = 32;

  localparam logic [SCALE_W-1:0] NOISE_SCALE_RESET = 16'd4096;
  localparam logic [SCALE_W-1:0] INV_SQRT2_Q16     = 16'd46341;
  localparam logic [SCALE_W:0]   ROUND_HALF_Q16    = 17'd32768;

  // Noise product n is Q6.42; rounding to sample units shifts by this minus the width.
  localparam int NOISE_Q_SHIFT = 42;

  localparam logic [LCG_W-1:0] LCG_MUL  = 32'd1103515245;
  localparam logic [LCG_W-1:0] LCG_ADD  = 32'd12345;
  // Two LCG steps folded into one: x*A*A + (A*C + C).
  localparam logic [LCG_W-1:0] LCG_MUL2 = 32'(64'(LCG_MUL) * 64'(LCG_MUL));
  localparam logic [LCG_W-1:0] LCG_ADD2 = 32'(64'(LCG_MUL) * 64'(LCG_ADD) + 64'(LCG_ADD));

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [SCALE_W-1:0] noise_scale;
    logic               complex_mode;
  } scale_cfg_t;

endpackage

[rtl/tan_front.sv]
// Front end: accepts items, draws and steps the table indices, forwards work to the queue.
module tan_front #(
  parameter int TABLE_BITS   = 10,
  parameter int BURST_LENGTH = 32,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [tan_pkg::CMD_W-1:0]          in_command,
  input  logic [TABLE_BITS-1:0]              in_table_address,
  input  logic [tan_pkg::TABLE_WORD_W-1:0]   in_table_word,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_sample_value,
  input  logic                               in_block_start,
  input  logic                               seed_load,
  input  logic [tan_pkg::LCG_W-1:0]          seed_value,
  output logic                               push_valid,
  input  logic                               push_ready,
  output tan_pkg::cmd_t                      push_cmd,
  output logic [TABLE_BITS-1:0]              push_addr,
  output logic [tan_pkg::TABLE_WORD_W-1:0]   push_word,
  output logic signed [SAMPLE_WIDTH-1:0]     push_sample,
  output logic [TABLE_BITS-1:0]              push_radius_idx,
  output logic [TABLE_BITS-1:0]              push_cosine_idx
);
  import tan_pkg::*;

  localparam int BURST_W = (BURST_LENGTH > 1) ? $clog2(BURST_LENGTH) : 1;

  logic [LCG_W-1:0]      lcg_r, lcg_nxt;
  logic [TABLE_BITS-1:0] radius_idx_r, radius_idx_nxt;
  logic [TABLE_BITS-1:0] cosine_idx_r, cosine_idx_nxt;
  logic [BURST_W-1:0]    burst_pos_r, burst_pos_nxt;

  logic [LCG_W-1:0]      draw_radius, draw_cosine;
  logic [BURST_W-1:0]    pos_base;
  logic [BURST_W:0]      pos_inc;
  logic                  new_draw;
  logic                  is_load, is_sample;
  logic                  sample_fire;

  always_comb begin
    is_load   = 1'b0;
    is_sample = 1'b0;
    unique case (cmd_t'(in_command))
      CMD_LOAD_RADIUS, CMD_LOAD_COSINE: is_load = 1'b1;
      CMD_SAMPLE: is_sample = 1'b1;
      default: ;
    endcase
  end

  assign in_ready    = push_ready;
  assign push_valid  = in_valid && (is_load || is_sample);
  assign sample_fire = in_valid && push_ready && is_sample;

  always_comb begin
    draw_radius = lcg_r * LCG_MUL + LCG_ADD;
    draw_cosine = lcg_r * LCG_MUL2 + LCG_ADD2;
    pos_base    = in_block_start ? '0 : burst_pos_r;
    new_draw    = (pos_base == '0);
    pos_inc     = {1'b0, pos_base} + 1'b1;
    burst_pos_nxt = (pos_inc == (BURST_W+1)'(BURST_LENGTH)) ? '0 : pos_inc[BURST_W-1:0];
    if (new_draw) begin
      radius_idx_nxt = draw_radius[TABLE_BITS-1:0];
      cosine_idx_nxt = draw_cosine[TABLE_BITS-1:0];
      lcg_nxt        = draw_cosine;
    end else begin
      radius_idx_nxt = TABLE_BITS'(radius_idx_r + 1'b1);
      cosine_idx_nxt = TABLE_BITS'(cosine_idx_r + 1'b1);
      lcg_nxt        = lcg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcg_r        <= '0;
      radius_idx_r <= '0;
      cosine_idx_r <= '0;
      burst_pos_r  <= '0;
    end else begin
      if (seed_load) begin
        lcg_r <= seed_value;
      end else if (sample_fire) begin
        lcg_r <= lcg_nxt;
      end
      if (sample_fire) begin
        radius_idx_r <= radius_idx_nxt;
        cosine_idx_r <= cosine_idx_nxt;
        burst_pos_r  <= burst_pos_nxt;
      end
    end
  end

  assign push_cmd        = cmd_t'(in_command);
  assign push_addr       = in_table_address;
  assign push_word       = in_table_word;
  assign push_sample     = in_sample_value;
  assign push_radius_idx = radius_idx_nxt;
  assign push_cosine_idx = cosine_idx_nxt;

endmodule

[rtl/tan_fifo.sv]
// Short queue between the front end and the noise datapath.
module tan_fifo #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);
  import tan_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [DATA_W-1:0] slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]    count_r;
  logic              do_push, do_pop;

  assign push_ready = (count_r != (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[rtl/tan_back.sv]
// Back end: table memories, noise multiply pipeline, rounding, saturating add, output register.
module tan_back #(
  parameter int TABLE_BITS   = 10,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tan_pkg::scale_cfg_t                scale_cfg,
  input  logic                               pop_valid,
  output logic                               pop_ready,
  input  tan_pkg::cmd_t                      pop_cmd,
  input  logic [TABLE_BITS-1:0]              pop_addr,
  input  logic [tan_pkg::TABLE_WORD_W-1:0]   pop_word,
  input  logic signed [SAMPLE_WIDTH-1:0]     pop_sample,
  input  logic [TABLE_BITS-1:0]              pop_radius_idx,
  input  logic [TABLE_BITS-1:0]              pop_cosine_idx,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]     out_noisy_sample,
  output logic                               out_saturated
);
  import tan_pkg::*;

  localparam int TABLE_SIZE = 1 << TABLE_BITS;
  localparam int PROD_W     = SCALE_W + TABLE_WORD_W;
  localparam int RAW_W      = PROD_W + TABLE_WORD_W;
  localparam int ROUND_W    = RAW_W + 1;
  localparam int SHIFT      = NOISE_Q_SHIFT - SAMPLE_WIDTH;
  localparam int NOISE_W    = ROUND_W - SHIFT;
  localparam int SUM_W      = NOISE_W + 1;
  localparam int SCL_W      = 2 * SCALE_W + 1;

  localparam logic signed [ROUND_W-1:0] ROUND_HALF = ROUND_W'(1) << (SHIFT - 1);
  localparam logic signed [SUM_W-1:0] SAT_MAX =
    {{(SUM_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

  logic [TABLE_WORD_W-1:0] radius_mem [TABLE_SIZE];
  logic [TABLE_WORD_W-1:0] cosine_mem [TABLE_SIZE];

  logic advance, fire;

  logic [SCALE_W-1:0] scale_r, scale_nxt;
  logic [SCL_W-1:0]   scale_prod;

  logic                           s1_valid_r;
  logic [TABLE_WORD_W-1:0]        radius_rd_r, cosine_rd_r;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample_r;

  logic                           s2_valid_r;
  logic [PROD_W-1:0]              prod_r;
  logic signed [TABLE_WORD_W-1:0] cosine_s2_r;
  logic signed [SAMPLE_WIDTH-1:0] s2_sample_r;

  logic                           s3_valid_r;
  logic signed [RAW_W-1:0]        raw_r;
  logic signed [SAMPLE_WIDTH-1:0] s3_sample_r;

  logic                           s4_valid_r;
  logic signed [NOISE_W-1:0]      noise_r;
  logic signed [SAMPLE_WIDTH-1:0] s4_sample_r;

  logic signed [ROUND_W-1:0]      biased;
  logic signed [ROUND_W-1:0]      shifted;
  logic signed [SUM_W-1:0]        sum;

  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r, out_sample_nxt;
  logic                           out_sat_r, out_sat_nxt;

  assign advance   = !out_valid_r || out_ready;
  assign pop_ready = advance;
  assign fire      = pop_valid && advance;

  // Effective scale, with the 1/sqrt2 factor in complex mode
  always_comb begin
    scale_prod = SCL_W'(scale_cfg.noise_scale) * SCL_W'(INV_SQRT2_Q16) + SCL_W'(ROUND_HALF_Q16);
    scale_nxt  = scale_cfg.complex_mode ? scale_prod[SCALE_W +: SCALE_W]
                                        : scale_cfg.noise_scale;
  end

  always_ff @(posedge clk) begin
    scale_r <= scale_nxt;
  end

  always_ff @(posedge clk) begin
    if (fire && (pop_cmd == CMD_LOAD_RADIUS)) begin
      radius_mem[pop_addr] <= pop_word;
    end
    if (advance) begin
      radius_rd_r <= radius_mem[pop_radius_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (pop_cmd == CMD_LOAD_COSINE)) begin
      cosine_mem[pop_addr] <= pop_word;
    end
    if (advance) begin
      cosine_rd_r <= cosine_mem[pop_cosine_idx];
    end
  end

  always_comb begin
    biased  = {raw_r[RAW_W-1], raw_r} + ROUND_HALF;
    shifted = biased >>> SHIFT;
    sum     = {{(SUM_W-SAMPLE_WIDTH){s4_sample_r[SAMPLE_WIDTH-1]}}, s4_sample_r}
            + {noise_r[NOISE_W-1], noise_r};
    if (sum > SAT_MAX) begin
      out_sample_nxt = SAT_MAX[SAMPLE_WIDTH-1:0];
      out_sat_nxt    = 1'b1;
    end else if (sum < SAT_MIN) begin
      out_sample_nxt = SAT_MIN[SAMPLE_WIDTH-1:0];
      out_sat_nxt    = 1'b1;
    end else begin
      out_sample_nxt = sum[SAMPLE_WIDTH-1:0];
      out_sat_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_sample_r  <= pop_sample;
      prod_r       <= PROD_W'(scale_r) * PROD_W'(radius_rd_r);
      cosine_s2_r  <= cosine_rd_r;
      s2_sample_r  <= s1_sample_r;
      raw_r        <= RAW_W'($signed({1'b0, prod_r})) * RAW_W'(cosine_s2_r);
      s3_sample_r  <= s2_sample_r;
      noise_r      <= shifted[NOISE_W-1:0];
      s4_sample_r  <= s3_sample_r;
      if (s4_valid_r) begin
        out_sample_r <= out_sample_nxt;
        out_sat_r    <= out_sat_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= fire && (pop_cmd == CMD_SAMPLE);
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_noisy_sample = out_sample_r;
  assign out_saturated    = out_sat_r;

endmodule

[rtl/table_awgn_noise_adder_core.sv]
// Top level of the table-based Gaussian noise adder.
//
// Usage:
//   Input channel (in_valid/in_ready) carries commands: load a radius entry,
//   load a cosine entry, or a sample that gets noise added. Command code 3 is
//   taken and dropped. Only sample commands produce a transfer on the output
//   channel (out_valid/out_ready): the saturated noisy sample and a clip flag.
//   Both tables must be loaded before any sample reads an entry.
//   Configuration (cfg_we/cfg_index/cfg_data) writes one of noise scale, LCG seed
//   or complex mode per write; write only while no item is in flight.
// Timing:
//   One item per cycle sustained while out_ready stays high. A sample accepted
//   into the queue moves out of the queue slot into the table read, scale
//   multiply, cosine multiply, rounding, saturating add into the output
//   register. The two-entry queue decouples the index generator from the datapath.
// Reset and stall:
//   Synchronous reset clears the LCG state, indices, burst count, queue and
//   all valid bits; table contents are kept. When out_ready is low with out_valid
//   high, the datapath holds, the queue fills and in_ready then drops.
module table_awgn_noise_adder_core #(
  parameter int TABLE_BITS   = 10,
  parameter int BURST_LENGTH = 32,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [tan_pkg::CMD_W-1:0]          in_command,
  input  logic [TABLE_BITS-1:0]              in_table_address,
  input  logic [tan_pkg::TABLE_WORD_W-1:0]   in_table_word,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_sample_value,
  input  logic                               in_block_start,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]     out_noisy_sample,
  output logic                               out_saturated,
  input  logic                               cfg_we,
  input  logic [tan_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tan_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tan_pkg::*;

  typedef struct packed {
    cmd_t                           cmd;
    logic [TABLE_BITS-1:0]          table_address;
    logic [TABLE_WORD_W-1:0]        table_word;
    logic signed [SAMPLE_WIDTH-1:0] sample_value;
    logic [TABLE_BITS-1:0]          radius_idx;
    logic [TABLE_BITS-1:0]          cosine_idx;
  } work_t;

  localparam int WORK_W = $bits(work_t);

  logic [SCALE_W-1:0] noise_scale_r;
  logic               complex_mode_r;
  logic               seed_load;
  scale_cfg_t         scale_cfg;

  logic  push_valid, push_ready;
  work_t push_work, pop_work;
  logic [WORK_W-1:0] pop_data;
  logic  fifo_valid, back_ready;

  assign seed_load = cfg_we && (cfg_index == REG_LCG_SEED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_scale_r  <= NOISE_SCALE_RESET;
      complex_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NOISE_SCALE:  noise_scale_r  <= cfg_data[SCALE_W-1:0];
        REG_COMPLEX_MODE: complex_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign scale_cfg.noise_scale  = noise_scale_r;
  assign scale_cfg.complex_mode = complex_mode_r;

  tan_front #(
    .TABLE_BITS   (TABLE_BITS),
    .BURST_LENGTH (BURST_LENGTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_table_address (in_table_address),
    .in_table_word    (in_table_word),
    .in_sample_value  (in_sample_value),
    .in_block_start   (in_block_start),
    .seed_load        (seed_load),
    .seed_value       (cfg_data[LCG_W-1:0]),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_cmd         (push_work.cmd),
    .push_addr        (push_work.table_address),
    .push_word        (push_work.table_word),
    .push_sample      (push_work.sample_value),
    .push_radius_idx  (push_work.radius_idx),
    .push_cosine_idx  (push_work.cosine_idx)
  );

  tan_fifo #(
    .DATA_W (WORK_W)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_work),
    .pop_valid  (fifo_valid),
    .pop_ready  (back_ready),
    .pop_data   (pop_data)
  );

  assign pop_work = work_t'(pop_data);

  tan_back #(
    .TABLE_BITS   (TABLE_BITS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .scale_cfg        (scale_cfg),
    .pop_valid        (fifo_valid),
    .pop_ready        (back_ready),
    .pop_cmd          (pop_work.cmd),
    .pop_addr         (pop_work.table_address),
    .pop_word         (pop_work.table_word),
    .pop_sample       (pop_work.sample_value),
    .pop_radius_idx   (pop_work.radius_idx),
    .pop_cosine_idx   (pop_work.cosine_idx),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_noisy_sample (out_noisy_sample),
    .out_saturated    (out_saturated)
  );

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_holds_datapath: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !back_ready)
    else $error("datapath pops while output is stalled");

  a_push_lands_in_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && push_ready && !(fifo_valid && back_ready)) |=> fifo_valid)
    else $error("queue lost a transfer");

endmodule

[tb/sv/awgn_result_checker.sv]
// Checker for the table-based noise adder: predicts noisy samples and compares results.
`timescale 1ns / 1ps
module awgn_result_checker #(
  parameter int TABLE_BITS   = 10,
  parameter int BURST_LENGTH = 32,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [tan_pkg::CMD_W-1:0]          in_command,
  input  logic [TABLE_BITS-1:0]              in_table_address,
  input  logic [tan_pkg::TABLE_WORD_W-1:0]   in_table_word,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_sample_value,
  input  logic                               in_block_start,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]     out_noisy_sample,
  input  logic                               out_saturated,
  input  logic                               cfg_we,
  input  logic [tan_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tan_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                 fail_count,
  output int                                 outstanding
);
  import tan_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] value;
    logic                           clipped;
  } noisy_t;

  noisy_t expected_noisy[$];

  logic [SCALE_W-1:0]      scale_reg = NOISE_SCALE_RESET;
  logic                    complex_reg = 1'b0;
  logic [LCG_W-1:0]        lcg = '0;
  logic [TABLE_BITS-1:0]   radius_idx = '0;
  logic [TABLE_BITS-1:0]   cosine_idx = '0;
  int unsigned             burst_pos = 0;
  logic [TABLE_WORD_W-1:0] radius_mem [1 << TABLE_BITS];
  logic [TABLE_WORD_W-1:0] cosine_mem [1 << TABLE_BITS];

  int mismatches = 0;
  int pending = 0;

  assign fail_count  = mismatches;
  assign outstanding = pending;

  function automatic logic [TABLE_BITS-1:0] draw_index();
    lcg = lcg * LCG_MUL + LCG_ADD;
    return lcg[TABLE_BITS-1:0];
  endfunction

  function automatic noisy_t add_noise(logic signed [SAMPLE_WIDTH-1:0] smp, logic restart);
    logic [63:0] s;
    longint      cv;
    longint      n;
    longint      noise;
    longint      sum;
    longint      maxv;
    longint      minv;
    noisy_t      r;
    if (restart) burst_pos = 0;
    if (burst_pos == 0) begin
      radius_idx = draw_index();
      cosine_idx = draw_index();
    end else begin
      radius_idx = radius_idx + 1'b1;
      cosine_idx = cosine_idx + 1'b1;
    end
    burst_pos = (burst_pos + 1) % BURST_LENGTH;

    s = 64'(scale_reg);
    if (complex_reg) s = (s * INV_SQRT2_Q16 + ROUND_HALF_Q16) >> 16;
    cv = longint'($signed(cosine_mem[cosine_idx]));
    n = longint'(s * radius_mem[radius_idx]) * cv;
    // round half up to sample units
    noise = (n + (longint'(1) <<< (NOISE_Q_SHIFT - SAMPLE_WIDTH - 1)))
            >>> (NOISE_Q_SHIFT - SAMPLE_WIDTH);
    sum  = longint'(smp) + noise;
    maxv = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    minv = -maxv - 1;
    r.clipped = 1'b0;
    if (sum > maxv) begin
      sum = maxv;
      r.clipped = 1'b1;
    end else if (sum < minv) begin
      sum = minv;
      r.clipped = 1'b1;
    end
    r.value = SAMPLE_WIDTH'(sum);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    noisy_t want;
    if (!rst_n) begin
      scale_reg   = NOISE_SCALE_RESET;
      complex_reg = 1'b0;
      lcg         = '0;
      radius_idx  = '0;
      cosine_idx  = '0;
      burst_pos   = 0;
      expected_noisy.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NOISE_SCALE:  scale_reg = cfg_data[SCALE_W-1:0];
          REG_LCG_SEED:     lcg = cfg_data[LCG_W-1:0];
          REG_COMPLEX_MODE: complex_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (in_command)
          CMD_LOAD_RADIUS: radius_mem[in_table_address] = in_table_word;
          CMD_LOAD_COSINE: cosine_mem[in_table_address] = in_table_word;
          CMD_SAMPLE:      expected_noisy.push_back(add_noise(in_sample_value, in_block_start));
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_noisy.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transfer: expected none, actual sample %0d saturated %0b",
                   $time, out_noisy_sample, out_saturated);
        end else begin
          want = expected_noisy.pop_front();
          if (want.value !== out_noisy_sample) begin
            mismatches++;
            $display("%0t: noisy sample mismatch: expected %0d, actual %0d",
                     $time, want.value, out_noisy_sample);
          end
          if (want.clipped !== out_saturated) begin
            mismatches++;
            $display("%0t: saturated flag mismatch: expected %0b, actual %0b",
                     $time, want.clipped, out_saturated);
          end
        end
      end
    end
    pending <= expected_noisy.size();
  end

endmodule

[tb/sv/table_awgn_noise_adder_core_tb.sv]
// Testbench top for the table-based noise adder: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module table_awgn_noise_adder_core_tb;
  import tan_pkg::*;

  localparam int TABLE_BITS   = 10;
  localparam int BURST_LENGTH = 32;
  localparam int SAMPLE_WIDTH = 16;
  localparam int TABLE_SIZE   = 1 << TABLE_BITS;

  localparam logic [CMD_W-1:0]     CMD_NONE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1800;
  localparam int PHASES       = 6;
  localparam int HOLD_CYCLES  = 200;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [CMD_W-1:0]               in_command = '0;
  logic [TABLE_BITS-1:0]          in_table_address = '0;
  logic [TABLE_WORD_W-1:0]        in_table_word = '0;
  logic signed [SAMPLE_WIDTH-1:0] in_sample_value = '0;
  logic                           in_block_start = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] out_noisy_sample;
  logic                           out_saturated;
  logic                           cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]           cfg_index = '0;
  logic [CFG_DATA_W-1:0]          cfg_data = '0;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;

  table_awgn_noise_adder_core #(
    .TABLE_BITS(TABLE_BITS), .BURST_LENGTH(BURST_LENGTH), .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_table_address(in_table_address), .in_table_word(in_table_word),
    .in_sample_value(in_sample_value), .in_block_start(in_block_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_noisy_sample(out_noisy_sample), .out_saturated(out_saturated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  awgn_result_checker #(
    .TABLE_BITS(TABLE_BITS), .BURST_LENGTH(BURST_LENGTH), .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_table_address(in_table_address), .in_table_word(in_table_word),
    .in_sample_value(in_sample_value), .in_block_start(in_block_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_noisy_sample(out_noisy_sample), .out_saturated(out_saturated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: stall pattern, plus a long hold-off on request
  initial begin : sink
    int mode;
    int span;
    int hold;
    mode = 0;
    span = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(16, 400);
        end
        span--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= ($urandom_range(0, 15) != 0);
        endcase
      end
    end
  end

  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      1: return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      2: return '0;
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic [TABLE_WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return TABLE_WORD_W'($urandom);
    endcase
  endfunction

  // returns at the edge where the transfer happens
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TABLE_BITS-1:0] addr,
                           input logic [TABLE_WORD_W-1:0] word,
                           input logic signed [SAMPLE_WIDTH-1:0] smp, input logic restart);
    int gap;
    gap = 0;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 48);
        gap = $urandom_range(1, 10);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_table_address <= addr;
    in_table_word    <= word;
    in_sample_value  <= smp;
    in_block_start   <= restart;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic configure(input logic [SCALE_W-1:0] scale, input logic [LCG_W-1:0] seed,
                           input logic cmode);
    drain();
    write_reg(REG_NOISE_SCALE, CFG_DATA_W'(scale));
    write_reg(REG_LCG_SEED, CFG_DATA_W'(seed));
    write_reg(REG_COMPLEX_MODE, CFG_DATA_W'(cmode));
    write_reg(REG_NONE, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(input logic restart);
    send_item(CMD_SAMPLE, TABLE_BITS'($urandom), TABLE_WORD_W'($urandom), pick_sample(),
              restart);
  endtask

  initial begin : stimulus
    int i;
    int n;
    int pick;
    logic [SCALE_W-1:0] scale;
    logic [LCG_W-1:0] seed;
    logic cmode;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // every entry written before any sample reads the tables
    for (i = 0; i < TABLE_SIZE; i++)
      send_item(CMD_LOAD_RADIUS, TABLE_BITS'(i), pick_word(), SAMPLE_WIDTH'($urandom),
                1'($urandom));
    for (i = 0; i < TABLE_SIZE; i++)
      send_item(CMD_LOAD_COSINE, TABLE_BITS'(i), pick_word(), SAMPLE_WIDTH'($urandom),
                1'($urandom));

    // directed: first sample with no block start, reset configuration
    send_item(CMD_SAMPLE, '0, '0, 16'sh1234, 1'b0);
    send_item(CMD_SAMPLE, '1, '1, 16'sh7FFF, 1'b0);
    send_item(CMD_SAMPLE, '0, '0, -16'sd32768, 1'b0);
    send_item(CMD_NONE, '1, '1, 16'sh7FFF, 1'b1);
    send_item(CMD_SAMPLE, '0, '0, '0, 1'b1);
    send_item(CMD_LOAD_RADIUS, '0, '1, '0, 1'b0);
    send_item(CMD_LOAD_RADIUS, '1, '0, '1, 1'b1);
    send_item(CMD_LOAD_COSINE, '0, 16'h8000, '0, 1'b0);
    send_item(CMD_LOAD_COSINE, '1, 16'h7FFF, '1, 1'b1);
    send_item(CMD_SAMPLE, '1, '0, -16'sd1, 1'b0);
    configure('1, '1, 1'b1);
    send_item(CMD_SAMPLE, '0, '0, 16'sh7FFF, 1'b1);
    send_item(CMD_SAMPLE, '0, '0, -16'sd32768, 1'b0);
    send_item(CMD_SAMPLE, '0, '0, '0, 1'b0);
    configure('0, '0, 1'b0);
    send_item(CMD_SAMPLE, '0, '0, 16'sh7FFF, 1'b1);
    send_item(CMD_SAMPLE, '0, '0, -16'sd32768, 1'b0);
    send_item(CMD_SAMPLE, '0, '0, 16'sh0001, 1'b0);
    configure('1, '0, 1'b0);
    send_item(CMD_SAMPLE, '0, '0, 16'sh7FFF, 1'b1);
    send_item(CMD_SAMPLE, '0, '0, -16'sd32768, 1'b0);
    send_item(CMD_SAMPLE, '0, '0, '0, 1'b1);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin scale = '1;                   seed = $urandom; cmode = 1'b0; end
        1: begin scale = NOISE_SCALE_RESET;    seed = $urandom; cmode = 1'b1; end
        2: begin scale = SCALE_W'($urandom);   seed = $urandom; cmode = 1'b0; end
        3: begin scale = '1;                   seed = '0;       cmode = 1'b1; end
        4: begin scale = SCALE_W'($urandom);   seed = '1;       cmode = 1'($urandom); end
        default: begin
          scale = SCALE_W'($urandom_range(0, 1023)); seed = $urandom; cmode = 1'b1;
        end
      endcase
      configure(scale, seed, cmode);
      n = 0;
      while (n < RANDOM_ITEMS / PHASES) begin
        if (phase == 2 && n == 100) begin
          hold_req = 1'b1;
          no_gaps = 1'b1;
        end
        if (phase == 2 && n == 160) no_gaps = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          send_item(CMD_LOAD_RADIUS, TABLE_BITS'($urandom), pick_word(),
                    SAMPLE_WIDTH'($urandom), 1'($urandom));
          n++;
        end else if (pick < 12) begin
          send_item(CMD_LOAD_COSINE, TABLE_BITS'($urandom), pick_word(),
                    SAMPLE_WIDTH'($urandom), 1'($urandom));
          n++;
        end else if (pick < 15) begin
          send_item(CMD_NONE, TABLE_BITS'($urandom), TABLE_WORD_W'($urandom),
                    SAMPLE_WIDTH'($urandom), 1'($urandom));
        end else begin
          send_sample($urandom_range(0, 39) == 0);
          n++;
        end
      end
    end

    drain();
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[files.f]
rtl/tan_pkg.sv
rtl/tan_front.sv
rtl/tan_fifo.sv
rtl/tan_back.sv
rtl/table_awgn_noise_adder_core.sv
tb/sv/awgn_result_checker.sv
tb/sv/table_awgn_noise_adder_core_tb.sv
